FILE: hw/rtl/mi4_pkg.sv
// Shared types, constants and index helpers for the 4x4 matrix inverse core.
package mi4_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int N_LANES        = 4;

  localparam logic [1:0] LAST_ROW  = 2'd3;
  localparam logic [2:0] LAST_TERM = 3'd5;

  typedef enum logic [2:0] {
    LN_IDLE,
    LN_COF,
    LN_DET,
    LN_DSET,
    LN_DIV,
    LN_DFIN
  } lane_state_t;

  typedef enum logic [2:0] {
    CT_IDLE,
    CT_START,
    CT_COF,
    CT_SING,
    CT_DIVGO,
    CT_DIV,
    CT_PUT
  } ctl_state_t;

  typedef struct packed {
    logic       start_cof;
    logic       start_div;
    logic [1:0] row;
  } lane_cmd_t;

  typedef struct packed {
    logic done;
    logic det_zero;
    logic clip;
  } lane_sts_t;

  typedef struct packed {
    logic       push;
    logic       singular;
    logic       last;
    logic [1:0] row;
  } mrg_cmd_t;

  // Column picked at position pos by the t-th permutation of a 3x3 determinant.
  // The first three permutations are even, the last three odd.
  function automatic logic [1:0] perm_col(input logic [2:0] t, input logic [1:0] pos);
    logic [5:0] cols;
    case (t)
      3'd0:    cols = {2'd2, 2'd1, 2'd0};
      3'd1:    cols = {2'd0, 2'd2, 2'd1};
      3'd2:    cols = {2'd1, 2'd0, 2'd2};
      3'd3:    cols = {2'd1, 2'd2, 2'd0};
      3'd4:    cols = {2'd2, 2'd0, 2'd1};
      3'd5:    cols = {2'd0, 2'd1, 2'd2};
      default: cols = {2'd2, 2'd1, 2'd0};
    endcase
    return cols[{pos, 1'b0} +: 2];
  endfunction

  function automatic logic perm_odd(input logic [2:0] t);
    return (t >= 3'd3);
  endfunction

  // Maps position a of a 3-element list to the 4-element index, skipping k.
  function automatic logic [1:0] skip_idx(input logic [1:0] a, input logic [1:0] k);
    return (a >= k) ? a + 2'd1 : a;
  endfunction

endpackage

FILE: hw/rtl/mi4_if.sv
// Handshake interfaces for the row load channel and the inverse result channel.
interface mi4_load_if #(parameter int DATA_WIDTH = mi4_pkg::DATA_WIDTH_DEF);
  logic                         valid;
  logic                         ready;
  logic [1:0]                   row_index;
  logic signed [DATA_WIDTH-1:0] in_c0;
  logic signed [DATA_WIDTH-1:0] in_c1;
  logic signed [DATA_WIDTH-1:0] in_c2;
  logic signed [DATA_WIDTH-1:0] in_c3;

  modport source(output valid, row_index, in_c0, in_c1, in_c2, in_c3, input ready);
  modport sink(input valid, row_index, in_c0, in_c1, in_c2, in_c3, output ready);
endinterface

interface mi4_res_if #(parameter int DATA_WIDTH = mi4_pkg::DATA_WIDTH_DEF);
  logic                         valid;
  logic                         ready;
  logic [1:0]                   out_row;
  logic signed [DATA_WIDTH-1:0] out_c0;
  logic signed [DATA_WIDTH-1:0] out_c1;
  logic signed [DATA_WIDTH-1:0] out_c2;
  logic signed [DATA_WIDTH-1:0] out_c3;
  logic                         singular;
  logic                         clipped;
  logic                         last;

  modport source(output valid, out_row, out_c0, out_c1, out_c2, out_c3, singular, clipped,
                 last, input ready);
  modport sink(input valid, out_row, out_c0, out_c1, out_c2, out_c3, singular, clipped,
               last, output ready);
endinterface

FILE: hw/rtl/mi4_lane.sv
// One lane: cofactors of one matrix row, the determinant, and one quotient per row.
module mi4_lane #(
  parameter int DATA_WIDTH = mi4_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = mi4_pkg::FRAC_BITS_DEF,
  parameter int LANE       = 0
) (
  input  logic                         clk,
  input  logic                         rst,
  input  mi4_pkg::lane_cmd_t           cmd,
  input  logic signed [DATA_WIDTH-1:0] mat [16],
  output mi4_pkg::lane_sts_t           sts,
  output logic signed [DATA_WIDTH-1:0] elem
);
  import mi4_pkg::*;

  localparam int W    = DATA_WIDTH;
  localparam int CW   = 3 * W + 2;
  localparam int DTW  = 4 * W + 2;
  localparam int NCH  = (CW + W - 1) / W;
  localparam int EXW  = NCH * W;
  localparam int CHW  = $clog2(NCH + 1);
  localparam int CIW  = $clog2(NCH);
  localparam int NW   = 3 * W + 2 + 2 * FRAC_BITS;
  localparam int RW   = (NW > DTW + W - 1) ? NW : DTW + W - 1;
  localparam int BW   = $clog2(W + 1);
  localparam int QIW  = $clog2(W);
  localparam int SHW  = $clog2((NCH - 1) * W + 1);
  localparam logic [1:0] LN = 2'(LANE);

  lane_state_t state, state_next;
  logic [1:0]              jc;
  logic [2:0]              tr;
  logic [1:0]              st;
  logic [CHW-1:0]          ch;
  logic [BW-1:0]           bc;
  logic signed [W-1:0]     mul_a;
  logic signed [W:0]       mul_b;
  logic signed [2*W:0]     prod;
  logic [2*W-1:0]          p;
  logic signed [DTW-1:0]   acc;
  logic signed [DTW-1:0]   acc_next;
  logic signed [DTW-1:0]   addend;
  logic [SHW-1:0]          shamt;
  logic                    acc_en;
  logic                    acc_sub;
  logic signed [CW-1:0]    cof [4];
  logic signed [DTW-1:0]   det;
  logic                    det_zero;
  logic [RW-1:0]           r;
  logic [RW-1:0]           dsh;
  logic [W-1:0]            q;
  logic                    big;
  logic                    neg;
  logic                    done_q;
  logic                    clip_q;
  logic [3:0]              ix;
  logic [3:0]              iy;
  logic [3:0]              iz;
  logic [3:0]              irow;
  logic signed [CW-1:0]    cof_sel;
  logic [CW-1:0]           cmag;
  logic [DTW-1:0]          dmag;
  logic [EXW-1:0]          cext;
  logic [W-1:0]            piece;
  logic [CIW-1:0]          ci;
  logic                    cof_last;
  logic                    det_last;
  logic                    div_ge;
  logic [W-1:0]            lim_pos;
  logic [W-1:0]            lim_neg;
  logic [W-1:0]            mag_sat;
  logic                    clip_now;

  // Operand addresses: rows skip this lane's row, columns skip the cofactor column.
  assign ix   = {skip_idx(2'd0, LN), skip_idx(perm_col(tr, 2'd0), jc)};
  assign iy   = {skip_idx(2'd1, LN), skip_idx(perm_col(tr, 2'd1), jc)};
  assign iz   = {skip_idx(2'd2, LN), skip_idx(perm_col(tr, 2'd2), jc)};
  assign irow = {LN, jc};

  assign cext  = EXW'(cof[jc]);
  assign ci    = ch[CIW-1:0];
  assign piece = cext[ci * W +: W];

  assign cof_last = (st == 2'd3) && (tr == LAST_TERM);
  assign det_last = (ch == CHW'(NCH)) && (jc == LAST_ROW);

  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    acc_en  = 1'b0;
    acc_sub = 1'b0;
    shamt   = '0;
    case (state)
      LN_COF: begin
        acc_sub = perm_odd(tr) ^ LN[0] ^ jc[0];
        case (st)
          2'd0: begin
            mul_a = mat[ix];
            mul_b = {mat[iy][W-1], mat[iy]};
          end
          2'd1: begin
            mul_a = mat[iz];
            mul_b = {1'b0, prod[W-1:0]};
          end
          2'd2: begin
            mul_a  = mat[iz];
            mul_b  = {p[2*W-1], p[2*W-1:W]};
            acc_en = 1'b1;
          end
          default: begin
            acc_en = 1'b1;
            shamt  = SHW'(W);
          end
        endcase
      end
      LN_DET: begin
        if (ch != CHW'(NCH)) begin
          mul_a = mat[irow];
          mul_b = (ci == CIW'(NCH - 1)) ? {piece[W-1], piece} : {1'b0, piece};
        end
        if (ch != '0) begin
          acc_en = 1'b1;
          shamt  = SHW'((ch - 1) * W);
        end
      end
      default: ;
    endcase
  end

  assign addend   = DTW'(prod) << shamt;
  assign acc_next = acc_sub ? acc - addend : acc + addend;

  assign cof_sel = cof[jc];
  assign cmag    = cof_sel[CW-1] ? CW'(-cof_sel) : cof_sel;
  assign dmag    = det[DTW-1] ? DTW'(-det) : det;
  assign div_ge  = (r >= dsh);

  assign lim_pos = {1'b0, {(W - 1){1'b1}}};
  assign lim_neg = {1'b1, {(W - 1){1'b0}}};

  always_comb begin
    if (neg) begin
      clip_now = big || (q > lim_neg);
      mag_sat  = clip_now ? lim_neg : q;
    end else begin
      clip_now = big || (q > lim_pos);
      mag_sat  = clip_now ? lim_pos : q;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      LN_IDLE: begin
        if (cmd.start_cof) begin
          state_next = LN_COF;
        end else if (cmd.start_div) begin
          state_next = LN_DSET;
        end
      end
      LN_COF: begin
        if (cof_last && (jc == LAST_ROW)) begin
          state_next = LN_DET;
        end
      end
      LN_DET: begin
        if (det_last) begin
          state_next = LN_IDLE;
        end
      end
      LN_DSET: state_next = LN_DIV;
      LN_DIV: begin
        if (bc == '0) begin
          state_next = LN_DFIN;
        end
      end
      LN_DFIN: state_next = LN_IDLE;
      default: state_next = LN_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= LN_IDLE;
      jc     <= '0;
      tr     <= '0;
      st     <= '0;
      ch     <= '0;
      bc     <= '0;
      done_q <= 1'b0;
    end else begin
      state  <= state_next;
      done_q <= ((state == LN_DET) && det_last) || (state == LN_DFIN);
      case (state)
        LN_IDLE: begin
          tr <= '0;
          st <= '0;
          ch <= '0;
          jc <= cmd.start_div ? cmd.row : 2'd0;
        end
        LN_COF: begin
          st <= st + 2'd1;
          if (st == 2'd3) begin
            tr <= (tr == LAST_TERM) ? 3'd0 : tr + 3'd1;
          end
          if (cof_last) begin
            jc <= jc + 2'd1;
          end
        end
        LN_DET: begin
          if (ch == CHW'(NCH)) begin
            ch <= '0;
            jc <= jc + 2'd1;
          end else begin
            ch <= ch + 1'b1;
          end
        end
        LN_DSET: bc <= BW'(W);
        LN_DIV:  bc <= bc - 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    case (state)
      LN_IDLE: acc <= '0;
      LN_COF: begin
        if (st == 2'd1) begin
          p <= prod[2*W-1:0];
        end
        if (cof_last) begin
          cof[jc] <= acc_next[CW-1:0];
          acc     <= '0;
        end else if (acc_en) begin
          acc <= acc_next;
        end
      end
      LN_DET: begin
        if (acc_en) begin
          acc <= acc_next;
        end
        if (det_last) begin
          det      <= acc_next;
          det_zero <= (acc_next == '0);
        end
      end
      LN_DSET: begin
        r   <= RW'(cmag) << (2 * FRAC_BITS);
        dsh <= RW'(dmag) << W;
        neg <= cof_sel[CW-1] ^ det[DTW-1];
        q   <= '0;
        big <= 1'b0;
      end
      LN_DIV: begin
        if (div_ge) begin
          r <= r - dsh;
          if (bc == BW'(W)) begin
            big <= 1'b1;
          end else begin
            q[bc[QIW-1:0]] <= 1'b1;
          end
        end
        dsh <= dsh >> 1;
      end
      LN_DFIN: begin
        elem   <= neg ? -mag_sat : mag_sat;
        clip_q <= clip_now;
      end
      default: ;
    endcase
  end

  assign sts.done     = done_q;
  assign sts.det_zero = det_zero;
  assign sts.clip     = clip_q;

endmodule

FILE: hw/rtl/mi4_merge.sv
// Result register that gathers the four lane quotients into one inverse row.
module mi4_merge #(
  parameter int DATA_WIDTH = mi4_pkg::DATA_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  mi4_pkg::mrg_cmd_t            cmd,
  input  logic signed [DATA_WIDTH-1:0] elem [4],
  input  mi4_pkg::lane_sts_t           sts [4],
  output logic                         free,
  mi4_res_if.source                    res
);
  import mi4_pkg::*;

  logic                         vld;
  logic [1:0]                   row;
  logic signed [DATA_WIDTH-1:0] col [4];
  logic                         sing;
  logic                         clip;
  logic                         lst;
  logic                         clip_any;

  assign clip_any = sts[0].clip | sts[1].clip | sts[2].clip | sts[3].clip;
  assign free     = !vld || res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (cmd.push) begin
      vld <= 1'b1;
    end else if (res.ready) begin
      vld <= 1'b0;
    end
  end

  // A singular result carries zero elements and never reports clipping.
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      row  <= cmd.row;
      sing <= cmd.singular;
      lst  <= cmd.last;
      clip <= !cmd.singular && clip_any;
      for (int k = 0; k < N_LANES; k++) begin
        col[k] <= cmd.singular ? '0 : elem[k];
      end
    end
  end

  assign res.valid    = vld;
  assign res.out_row  = row;
  assign res.out_c0   = col[0];
  assign res.out_c1   = col[1];
  assign res.out_c2   = col[2];
  assign res.out_c3   = col[3];
  assign res.singular = sing;
  assign res.clipped  = clip;
  assign res.last     = lst;

endmodule

FILE: hw/rtl/matrix4x4_inverse_core.sv
// Top level of the 4x4 fixed-point matrix inverse: row store, sequencer, lanes, result merge.
//
//   Channel  Dir  Carries                                     Transfer when
//   load     in   row_index, in_c0..in_c3 (one matrix row)    load.valid && load.ready
//   result   out  out_row, out_c0..out_c3, singular, clipped,  result.valid && result.ready
//                 last (one inverse row or a singular flag)
//
// A transfer of row 0, 1 or 2 only stores that row. A row 3 transfer starts an inversion that
// occupies the block for the cofactor and determinant work, limited by the one shared
// multiplier in each lane, then for one division per inverse row, done by the
// one-bit-per-cycle divider in each lane.
// A singular matrix yields its single result after the cofactor phase.
// Reset clears the matrix store to zero and returns every sequencer to idle.
// The load channel is held off for the whole inversion; a stalled result only delays the
// next row's hand-over, and the lanes keep their quotients until it is taken.
module matrix4x4_inverse_core #(
  parameter int DATA_WIDTH = mi4_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = mi4_pkg::FRAC_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  mi4_load_if.sink  load,
  mi4_res_if.source result
);
  import mi4_pkg::*;

  localparam int W = DATA_WIDTH;

  logic signed [W-1:0] mat [16];
  logic signed [W-1:0] in_col [4];
  logic signed [W-1:0] elem [4];
  lane_cmd_t           lcmd;
  lane_sts_t           sts [4];
  mrg_cmd_t            mcmd;
  logic                mrg_free;
  ctl_state_t          state, state_next;
  logic [1:0]          row_q, row_next;
  logic                load_fire;

  assign in_col[0] = load.in_c0;
  assign in_col[1] = load.in_c1;
  assign in_col[2] = load.in_c2;
  assign in_col[3] = load.in_c3;

  // New rows are taken only while no inversion is in flight, so the lanes see a
  // stable matrix for the whole of their cofactor pass.
  assign load.ready = (state == CT_IDLE);
  assign load_fire  = load.valid && load.ready;

  // The store is reset to zero: rows never written count as zero, and rows of
  // earlier matrices are reused until overwritten.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 16; i++) begin
        mat[i] <= '0;
      end
    end else if (load_fire) begin
      for (int j = 0; j < N_LANES; j++) begin
        mat[{load.row_index, 2'(j)}] <= in_col[j];
      end
    end
  end

  // Sequencer. The lanes run in lockstep, so lane 0's status stands for all four.
  always_comb begin
    state_next = state;
    row_next   = row_q;
    lcmd       = '0;
    mcmd       = '0;
    unique case (state)
      CT_IDLE: begin
        if (load_fire && (load.row_index == LAST_ROW)) begin
          state_next = CT_START;
        end
      end
      CT_START: begin
        lcmd.start_cof = 1'b1;
        state_next     = CT_COF;
      end
      CT_COF: begin
        if (sts[0].done) begin
          if (sts[0].det_zero) begin
            state_next = CT_SING;
          end else begin
            row_next   = 2'd0;
            state_next = CT_DIVGO;
          end
        end
      end
      CT_SING: begin
        if (mrg_free) begin
          mcmd.push     = 1'b1;
          mcmd.singular = 1'b1;
          mcmd.last     = 1'b1;
          mcmd.row      = 2'd0;
          state_next    = CT_IDLE;
        end
      end
      CT_DIVGO: begin
        lcmd.start_div = 1'b1;
        lcmd.row       = row_q;
        state_next     = CT_DIV;
      end
      CT_DIV: begin
        if (sts[0].done) begin
          state_next = CT_PUT;
        end
      end
      CT_PUT: begin
        if (mrg_free) begin
          mcmd.push = 1'b1;
          mcmd.row  = row_q;
          mcmd.last = (row_q == LAST_ROW);
          if (row_q == LAST_ROW) begin
            state_next = CT_IDLE;
          end else begin
            row_next   = row_q + 2'd1;
            state_next = CT_DIVGO;
          end
        end
      end
      default: state_next = CT_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CT_IDLE;
      row_q <= '0;
    end else begin
      state <= state_next;
      row_q <= row_next;
    end
  end

  // Lane k owns column k of the inverse: it forms the cofactors of matrix row k,
  // expands the determinant along that row, and divides one cofactor per result row.
  for (genvar k = 0; k < N_LANES; k++) begin : g_lane
    mi4_lane #(
      .DATA_WIDTH(DATA_WIDTH),
      .FRAC_BITS (FRAC_BITS),
      .LANE      (k)
    ) u_lane (
      .clk (clk),
      .rst (rst),
      .cmd (lcmd),
      .mat (mat),
      .sts (sts[k]),
      .elem(elem[k])
    );
  end

  // The merge stage gathers the four quotients and their clip flags into one result.
  mi4_merge #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_merge (
    .clk (clk),
    .rst (rst),
    .cmd (mcmd),
    .elem(elem),
    .sts (sts),
    .free(mrg_free),
    .res (result)
  );

`ifndef SYNTH
  a_lanes_lockstep: assert property (@(posedge clk) disable iff (rst)
    sts[0].done |-> (sts[1].done && sts[2].done && sts[3].done))
    else $error("lanes finished out of step");

  a_det_agree: assert property (@(posedge clk) disable iff (rst)
    sts[0].done |-> ((sts[1].det_zero == sts[0].det_zero) &&
                     (sts[2].det_zero == sts[0].det_zero) &&
                     (sts[3].det_zero == sts[0].det_zero)))
    else $error("lanes disagree on a zero determinant");

  a_push_has_room: assert property (@(posedge clk) disable iff (rst)
    mcmd.push |-> mrg_free)
    else $error("result pushed while the output register was full");

  a_singular_last: assert property (@(posedge clk) disable iff (rst)
    (mcmd.push && mcmd.singular) |-> (mcmd.last && (state == CT_SING)))
    else $error("singular result not marked as the last of its run");
`endif

endmodule

FILE: test/tb.sv
// Self-checking testbench for the 4x4 fixed-point matrix inverse core.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mi4_pkg::*;

  localparam int DW     = 32;
  localparam int FB     = 16;
  localparam int IDLE_LIMIT = 5000;
  localparam int RAND_ITEMS = 480;

  typedef logic signed [255:0] wide_t;
  typedef logic signed [DW-1:0] elem_t;

  typedef struct {
    logic [1:0] row;
    elem_t      c[4];
    bit         drain;
  } row_item_t;

  typedef struct {
    logic [1:0] row;
    elem_t      c[4];
    bit         singular;
    bit         clipped;
    bit         last;
  } inv_row_t;

  logic clk;
  logic rst;

  mi4_load_if #(.DATA_WIDTH(DW)) load_ch();
  mi4_res_if  #(.DATA_WIDTH(DW)) res_ch();

  matrix4x4_inverse_core #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) i_dut (
    .clk    (clk),
    .rst    (rst),
    .load   (load_ch),
    .result (res_ch)
  );

  // The clock and a single reset pulse at the start of the run.
  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  row_item_t pend_rows[$];
  inv_row_t  inv_exp[$];
  elem_t     shadow[16];
  int        n_errors;
  bit        load_taken;

  // Every input of the block holds a known value from time zero.
  initial begin
    rst             = 1'b1;
    load_ch.valid     = 1'b0;
    load_ch.row_index = '0;
    load_ch.in_c0     = '0;
    load_ch.in_c1     = '0;
    load_ch.in_c2     = '0;
    load_ch.in_c3     = '0;
    res_ch.ready      = 1'b0;
    n_errors          = 0;
    load_taken        = 1'b0;
    foreach (shadow[k]) shadow[k] = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor. It mirrors the matrix store and, when row 3 arrives, works out
  // the exact cofactors and determinant with wide signed arithmetic, so that
  // no intermediate value can overflow.
  // ---------------------------------------------------------------------------

  // Determinant of the 3x3 minor left after striking out row r and column c.
  function automatic wide_t minor_det(int r, int c);
    int    rr[3];
    int    cc[3];
    int    k;
    wide_t m[3][3];
    k = 0;
    for (int i = 0; i < 4; i++) if (i != r) begin
      rr[k] = i;
      k++;
    end
    k = 0;
    for (int i = 0; i < 4; i++) if (i != c) begin
      cc[k] = i;
      k++;
    end
    for (int a = 0; a < 3; a++)
      for (int b = 0; b < 3; b++) m[a][b] = shadow[rr[a] * 4 + cc[b]];
    return m[0][0] * (m[1][1] * m[2][2] - m[1][2] * m[2][1])
         - m[0][1] * (m[1][0] * m[2][2] - m[1][2] * m[2][0])
         + m[0][2] * (m[1][0] * m[2][1] - m[1][1] * m[2][0]);
  endfunction

  // Quotient truncated toward zero and clamped to the element range. The top
  // bit of the return value says whether the clamp was applied.
  function automatic logic [DW:0] clamped_quotient(wide_t num, wide_t den);
    logic          neg;
    logic [255:0]  an;
    logic [255:0]  ad;
    logic [255:0]  q;
    logic          clip;
    neg  = (num < 0) != (den < 0);
    an   = (num < 0) ? -num : num;
    ad   = (den < 0) ? -den : den;
    q    = an / ad;
    clip = 1'b0;
    if (neg) begin
      if (q > (256'd1 << (DW - 1))) begin
        clip = 1'b1;
        q    = 256'd1 << (DW - 1);
      end
      q = -q;
    end else if (q > ((256'd1 << (DW - 1)) - 1)) begin
      clip = 1'b1;
      q    = (256'd1 << (DW - 1)) - 1;
    end
    return {clip, q[DW-1:0]};
  endfunction

  // Stores one row and, for the last row, queues the expected inverse rows.
  function automatic void predict_inverse(logic [1:0] row, elem_t c0, elem_t c1,
                                          elem_t c2, elem_t c3);
    wide_t       cof[4][4];
    wide_t       det;
    inv_row_t    r;
    logic [DW:0] qv;
    shadow[row * 4 + 0] = c0;
    shadow[row * 4 + 1] = c1;
    shadow[row * 4 + 2] = c2;
    shadow[row * 4 + 3] = c3;
    if (row != LAST_ROW) return;
    det = '0;
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 4; j++)
        cof[i][j] = ((i + j) % 2 == 1) ? -minor_det(i, j) : minor_det(i, j);
    for (int j = 0; j < 4; j++) det = det + wide_t'(shadow[j]) * cof[0][j];
    if (det == 0) begin
      r.row      = 2'd0;
      foreach (r.c[j]) r.c[j] = '0;
      r.singular = 1'b1;
      r.clipped  = 1'b0;
      r.last     = 1'b1;
      inv_exp.push_back(r);
      return;
    end
    for (int i = 0; i < 4; i++) begin
      r.row      = i[1:0];
      r.singular = 1'b0;
      r.clipped  = 1'b0;
      r.last     = (i == 3);
      // The inverse is the transposed cofactor matrix over the determinant.
      for (int j = 0; j < 4; j++) begin
        qv        = clamped_quotient(cof[j][i] <<< (2 * FB), det);
        r.c[j]    = qv[DW-1:0];
        r.clipped = r.clipped | qv[DW];
      end
      inv_exp.push_back(r);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Driver for the load channel. Items go out in bursts of random length with
  // random gaps between them. An item marked to drain is held back until every
  // expected result has been taken.
  // ---------------------------------------------------------------------------
  int burst_left = 0;
  int gap_left   = 0;

  always @(negedge clk) begin
    row_item_t it;
    logic      nv;
    if (!rst && (load_taken || !load_ch.valid)) begin
      nv = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (pend_rows.size() > 0 && !(pend_rows[0].drain && inv_exp.size() != 0)) begin
        it = pend_rows.pop_front();
        load_ch.row_index <= it.row;
        load_ch.in_c0     <= it.c[0];
        load_ch.in_c1     <= it.c[1];
        load_ch.in_c2     <= it.c[2];
        load_ch.in_c3     <= it.c[3];
        nv = 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 15);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
      end
      load_ch.valid <= nv;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver for the result channel. Its stall pattern switches at random
  // intervals between always ready, a random mix and long stalls.
  // ---------------------------------------------------------------------------
  int ready_mode  = 0;
  int mode_cycles = 0;
  int stall_left  = 0;

  always @(negedge clk) begin
    logic nr;
    if (!rst) begin
      if (mode_cycles == 0) begin
        ready_mode  = $urandom_range(0, 2);
        mode_cycles = $urandom_range(100, 600);
      end
      mode_cycles--;
      case (ready_mode)
        0: nr = 1'b1;
        1: nr = 1'($urandom_range(0, 1));
        default: begin
          if (stall_left > 0) begin
            stall_left--;
            nr = 1'b0;
          end else begin
            nr = 1'b1;
            if ($urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 30);
          end
        end
      endcase
      res_ch.ready <= nr;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor. On each rising edge it records a load transfer into the
  // predictor and checks a result transfer against the oldest expectation.
  // ---------------------------------------------------------------------------
  task automatic check_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      n_errors++;
    end
  endtask

  int idle_cycles = 0;

  always @(posedge clk) begin
    inv_row_t e;
    if (rst) begin
      load_taken = 1'b0;
    end else begin
      load_taken = load_ch.valid && load_ch.ready;
      if (load_taken)
        predict_inverse(load_ch.row_index, load_ch.in_c0, load_ch.in_c1, load_ch.in_c2,
                        load_ch.in_c3);
      if (res_ch.valid && res_ch.ready) begin
        if (inv_exp.size() == 0) begin
          $error("result transfer with no result expected");
          n_errors++;
        end else begin
          e = inv_exp.pop_front();
          check_field("out_row", e.row, res_ch.out_row);
          check_field("out_c0", DW'(e.c[0]), DW'(res_ch.out_c0));
          check_field("out_c1", DW'(e.c[1]), DW'(res_ch.out_c1));
          check_field("out_c2", DW'(e.c[2]), DW'(res_ch.out_c2));
          check_field("out_c3", DW'(e.c[3]), DW'(res_ch.out_c3));
          check_field("singular", e.singular, res_ch.singular);
          check_field("clipped", e.clipped, res_ch.clipped);
          check_field("last", e.last, res_ch.last);
        end
      end
      // Watchdog: the run is abandoned after too long without any transfer.
      if (load_taken || (res_ch.valid && res_ch.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus.
  // ---------------------------------------------------------------------------
  task automatic put_row(logic [1:0] row, elem_t c0, elem_t c1, elem_t c2, elem_t c3,
                         bit drain = 1'b0);
    row_item_t it;
    it.row   = row;
    it.c[0]  = c0;
    it.c[1]  = c1;
    it.c[2]  = c2;
    it.c[3]  = c3;
    it.drain = drain;
    pend_rows.push_back(it);
  endtask

  // Element value: full-range random, a small value within plus or minus 4.0 (Q16.16), or an extreme.
  function automatic elem_t pick_elem(int style);
    int sel;
    case (style)
      0: return elem_t'($urandom);
      1: return elem_t'($urandom_range(0, 32'h80000)) - 32'sh40000;
      default: begin
        sel = $urandom_range(0, 5);
        case (sel)
          0: return '0;
          1: return 32'sd1;
          2: return -32'sd1;
          3: return 32'sh7fffffff;
          4: return 32'sh80000000;
          default: return 32'sh10000;
        endcase
      end
    endcase
  endfunction

  function automatic int pick_style();
    int p;
    p = $urandom_range(0, 9);
    return (p < 6) ? 1 : (p < 9) ? 0 : 2;
  endfunction

  initial begin
    elem_t one;
    int    kind;
    int    n_items;
    int    style;
    elem_t d;
    one = 32'sh10000;

    // A row 3 alone right after reset inverts the cleared store: singular.
    put_row(LAST_ROW, 0, 0, 0, 0);
    // Identity.
    put_row(0, one, 0, 0, 0);
    put_row(1, 0, one, 0, 0);
    put_row(2, 0, 0, one, 0);
    put_row(LAST_ROW, 0, 0, 0, one, 1'b1);
    // Stale rows: only the last row changes, to twice the identity row.
    put_row(LAST_ROW, 0, 0, 0, 2 * one);
    // Tiny diagonal entries of both signs: the inverse saturates both ways.
    put_row(0, 1, 0, 0, 0);
    put_row(1, 0, -1, 0, 0);
    put_row(2, 0, 0, one, 0);
    put_row(LAST_ROW, 0, 0, 0, one);
    // Largest and most negative elements, on the diagonal and off it.
    put_row(0, 32'sh7fffffff, 0, 0, 0);
    put_row(1, 0, 32'sh80000000, 0, 0);
    put_row(2, 0, 0, 32'sh7fffffff, 32'sh80000000);
    put_row(LAST_ROW, 32'sh80000000, 0, 0, 32'sh7fffffff);
    // Two equal rows: singular with nonzero content.
    put_row(1, one, 2 * one, -one, 3);
    put_row(2, one, 2 * one, -one, 3);
    put_row(LAST_ROW, 5, -7, one, 32'sh7fffffff);
    // Every element at an extreme.
    put_row(0, 32'sh80000000, 32'sh7fffffff, -1, 1);
    put_row(1, 32'sh7fffffff, 32'sh80000000, 1, -1);
    put_row(2, -1, 1, 32'sh80000000, 32'sh7fffffff);
    put_row(LAST_ROW, 1, -1, 32'sh7fffffff, 32'sh80000000);

    // Random part: mostly whole matrices, the rest lone or partial rows.
    n_items = 0;
    while (n_items < RAND_ITEMS) begin
      kind = $urandom_range(0, 19);
      if (kind < 16) begin
        style = pick_style();
        for (int r = 0; r < 4; r++) begin
          // Some matrices get whole diagonal entries from 4 to 40 of either sign, which tends
          // to keep them well conditioned so that the inverse seldom saturates.
          d = (kind < 5) ? elem_t'($urandom_range(4, 40)) * one
                         * (($urandom_range(0, 1) == 1) ? 1 : -1) : pick_elem(style);
          put_row(r[1:0],
                  (r == 0) ? d : pick_elem(style), (r == 1) ? d : pick_elem(style),
                  (r == 2) ? d : pick_elem(style), (r == 3) ? d : pick_elem(style),
                  (r == 0) && ($urandom_range(0, 29) == 0));
        end
        n_items += 4;
      end else begin
        style = pick_style();
        put_row(2'($urandom_range(0, 3)), pick_elem(style), pick_elem(style),
                pick_elem(style), pick_elem(style));
        n_items++;
      end
    end

    @(negedge rst);
    while (pend_rows.size() != 0 || load_ch.valid || inv_exp.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (n_errors == 0 && inv_exp.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: matrix4x4_inverse_core.f
hw/rtl/mi4_pkg.sv
hw/rtl/mi4_if.sv
hw/rtl/mi4_lane.sv
hw/rtl/mi4_merge.sv
hw/rtl/matrix4x4_inverse_core.sv
test/tb.sv
